### rtl/sas_cs_pkg.sv
// Shared types and character constants for the comment stripper.
package sas_cs_pkg;

    localparam int unsigned QueueDepthDef = 4;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [3:0] {
        MODE_START = 4'b0001,
        MODE_TEXT  = 4'b0010,
        MODE_BLOCK = 4'b0100,
        MODE_STMT  = 4'b1000
    } scan_mode_t;

    typedef enum logic [3:0] {
        HELD_NONE  = 4'b0001,
        HELD_SLASH = 4'b0010,
        HELD_PCT   = 4'b0100,
        HELD_STAR  = 4'b1000
    } held_char_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_beat_t;

    typedef struct packed {
        logic [1:0] cnt;
        out_beat_t  beat0;
        out_beat_t  beat1;
    } push_t;

endpackage

### rtl/sas_cs_scan.sv
// Input register, comment scan state and per-beat result decode.
module sas_cs_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sas_cs_pkg::in_beat_t s_data,
    input  logic                room,
    output sas_cs_pkg::push_t   push
);
    import sas_cs_pkg::*;

    logic       vld_reg, vld_next;
    in_beat_t   data_reg;
    scan_mode_t mode_reg, mode_next;
    held_char_t held_reg, held_next;
    logic       fire;
    logic [7:0] c;
    logic       consumed, e_set, e_cur, e_flush, blank;
    logic [7:0] set_ch, flush_ch;
    scan_mode_t mode_a;
    held_char_t held_a;
    logic [1:0] cnt;

    assign fire    = vld_reg && room;
    assign s_ready = !vld_reg || room;
    assign c       = data_reg.in_byte;
    assign blank   = c inside {CH_SP, CH_NL, CH_TAB};

    always_comb begin
        consumed = 1'b0;
        e_set    = 1'b0;
        e_cur    = 1'b0;
        set_ch   = CH_SLASH;
        mode_a   = mode_reg;
        held_a   = HELD_NONE;
        case (held_reg)
            HELD_SLASH: begin
                if (c == CH_STAR) begin
                    mode_a   = MODE_BLOCK;
                    consumed = 1'b1;
                end else begin
                    e_set = 1'b1;
                end
            end
            HELD_PCT: begin
                set_ch = CH_PCT;
                if (c == CH_STAR) begin
                    mode_a   = MODE_STMT;
                    consumed = 1'b1;
                end else begin
                    e_set = 1'b1;
                end
            end
            HELD_STAR: begin
                if (c == CH_SLASH) begin
                    mode_a   = MODE_TEXT;
                    consumed = 1'b1;
                end
            end
            default: ;
        endcase
        if (!consumed) begin
            case (mode_reg)
                MODE_START: begin
                    if (blank || c == CH_SEMI) begin
                        e_cur = 1'b1;
                    end else if (c == CH_STAR) begin
                        mode_a = MODE_STMT;
                    end else if (c == CH_SLASH) begin
                        held_a = HELD_SLASH;
                    end else if (c == CH_PCT) begin
                        held_a = HELD_PCT;
                    end else begin
                        e_cur  = 1'b1;
                        mode_a = MODE_TEXT;
                    end
                end
                MODE_TEXT: begin
                    if (c == CH_SEMI) begin
                        e_cur  = 1'b1;
                        mode_a = MODE_START;
                    end else if (c == CH_SLASH) begin
                        held_a = HELD_SLASH;
                    end else begin
                        e_cur = 1'b1;
                    end
                end
                MODE_BLOCK: begin
                    if (c == CH_STAR) begin
                        held_a = HELD_STAR;
                    end
                end
                MODE_STMT: begin
                    if (c == CH_SEMI) begin
                        mode_a = MODE_START;
                    end
                end
                default: ;
            endcase
        end
        e_flush  = 1'b0;
        flush_ch = (held_a == HELD_PCT) ? CH_PCT : CH_SLASH;
        mode_next = mode_a;
        held_next = held_a;
        if (data_reg.stream_last) begin
            e_flush   = (held_a == HELD_SLASH) || (held_a == HELD_PCT);
            mode_next = MODE_START;
            held_next = HELD_NONE;
        end
    end

    always_comb begin
        cnt = 2'(e_set) + 2'(e_cur) + 2'(e_flush);
        push.cnt = fire ? cnt : 2'd0;
        push.beat0.out_byte = e_set ? set_ch : (e_cur ? c : flush_ch);
        push.beat0.run_last = (cnt == 2'd1);
        push.beat1.out_byte = (e_set && e_cur) ? c : flush_ch;
        push.beat1.run_last = 1'b1;
    end

    assign vld_next = s_ready ? s_valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= 1'b0;
            mode_reg <= MODE_START;
            held_reg <= HELD_NONE;
        end else begin
            vld_reg <= vld_next;
            if (fire) begin
                mode_reg <= mode_next;
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    a_star_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg == HELD_STAR) |-> (mode_reg == MODE_BLOCK))
        else $error("held star outside block comment");

    a_pct_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg == HELD_PCT) |-> (mode_reg == MODE_START))
        else $error("held percent outside statement start");

endmodule

### rtl/sas_cs_outq.sv
// Result queue taking up to two beats per cycle and giving one while m_ready is high.
module sas_cs_outq #(
    parameter int unsigned DEPTH = sas_cs_pkg::QueueDepthDef
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sas_cs_pkg::push_t     push,
    output logic                  room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sas_cs_pkg::out_beat_t m_data
);
    import sas_cs_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LastIdx = PW'(DEPTH - 1);

    out_beat_t     mem [DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next, wr_inc;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rd_reg];
    assign room    = ({1'b0, count_reg} + (CW+1)'(2)) <= (CW+1)'(DEPTH);
    assign wr_inc  = (wr_reg == LastIdx) ? '0 : wr_reg + PW'(1);

    always_comb begin
        wr_next = wr_reg;
        case (push.cnt)
            2'd1: wr_next = wr_inc;
            2'd2: wr_next = (wr_inc == LastIdx) ? '0 : wr_inc + PW'(1);
            default: ;
        endcase
        rd_next = pop ? ((rd_reg == LastIdx) ? '0 : rd_reg + PW'(1)) : rd_reg;
        count_next = count_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_reg] <= push.beat0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_inc] <= push.beat1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt != 2'd0) |-> room)
        else $error("push without room");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count past depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("queue count moved while idle");

endmodule

### rtl/sas_comment_stripper_top.sv
// Top level of the comment stripper: scan stage and result queue.
//
//   channel | dir | ports                      | beat
//   s_      | in  | s_valid s_ready s_data     | in_byte, stream_last
//   m_      | out | m_valid m_ready m_data     | out_byte, run_last
//
// One input beat per cycle while the queue has room; a beat's results are
// decoded from the input register and written into the queue, then can leave.
// A beat yields zero, one or two results; the queue drains one per cycle while m_ready is high.
// Input is taken while the input register is empty or the queue has two free
// entries, so a stalled m_ side holds s_ready low once the queue holds more
// than QUEUE_DEPTH - 2 beats and a beat waits in the input register.
// aresetn (synchronous, active low) returns to statement start, nothing held.
module sas_comment_stripper_top #(
    parameter int unsigned QUEUE_DEPTH = sas_cs_pkg::QueueDepthDef
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sas_cs_pkg::in_beat_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sas_cs_pkg::out_beat_t m_data
);
    import sas_cs_pkg::*;

    push_t push;
    logic  room;

    sas_cs_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .room    (room),
        .push    (push)
    );

    sas_cs_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### tb/sas_comment_stripper_top_test.sv
// Self-checking bench for the comment stripper: directed byte table, then random source text.
`timescale 1ns / 100ps

module sas_comment_stripper_top_test;

    import sas_cs_pkg::*;

    localparam int RandPerPhase = 308;
    localparam int StallLimit   = 4000;
    localparam out_beat_t NoBeat = '0;

    typedef struct packed {
        in_beat_t   beat;
        logic       typed;
        logic [1:0] n;
        out_beat_t  r0;
        out_beat_t  r1;
    } dir_row_t;

    localparam dir_row_t DirTab [27] = '{
        '{'{8'h00, 1'b0}, 1'b1, 2'd1, '{8'h00, 1'b1}, NoBeat},
        '{'{8'hFF, 1'b0}, 1'b1, 2'd1, '{8'hFF, 1'b1}, NoBeat},
        '{'{CH_SEMI, 1'b0}, 1'b1, 2'd1, '{CH_SEMI, 1'b1}, NoBeat},
        '{'{CH_SP, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_TAB, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_NL, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_STAR, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_SEMI, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_PCT, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_STAR, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{8'h78, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_SEMI, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_PCT, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{8'h62, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_SLASH, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_STAR, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_STAR, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_STAR, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{8'h71, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_STAR, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_SLASH, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_SLASH, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_SLASH, 1'b1}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_PCT, 1'b1}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_SLASH, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_STAR, 1'b0}, 1'b0, 2'd0, NoBeat, NoBeat},
        '{'{CH_STAR, 1'b1}, 1'b0, 2'd0, NoBeat, NoBeat}
    };

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    scan_mode_t pred_mode = MODE_START;
    held_char_t pred_held = HELD_NONE;
    out_beat_t  step_res [2];
    int         step_cnt;
    out_beat_t  kept_q [$];
    logic [7:0] src_q [$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         fail_cnt = 0;
    int         stall_cycles = 0;

    sas_comment_stripper_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void keep_char(input logic [7:0] c);
        step_res[step_cnt] = '{c, 1'b0};
        step_cnt++;
    endfunction

    task automatic strip_byte(input in_beat_t b);
        logic [7:0] c;
        logic       consumed;
        held_char_t held;
        c = b.in_byte;
        consumed = 1'b0;
        held = pred_held;
        pred_held = HELD_NONE;
        step_cnt = 0;
        case (held)
            HELD_SLASH: begin
                if (c == CH_STAR) begin
                    pred_mode = MODE_BLOCK;
                    consumed = 1'b1;
                end else begin
                    keep_char(CH_SLASH);
                end
            end
            HELD_PCT: begin
                if (c == CH_STAR) begin
                    pred_mode = MODE_STMT;
                    consumed = 1'b1;
                end else begin
                    keep_char(CH_PCT);
                end
            end
            HELD_STAR: begin
                if (c == CH_SLASH) begin
                    pred_mode = MODE_TEXT;
                    consumed = 1'b1;
                end
            end
            default: ;
        endcase
        if (!consumed) begin
            case (pred_mode)
                MODE_START: begin
                    if (c inside {CH_SP, CH_NL, CH_TAB, CH_SEMI}) begin
                        keep_char(c);
                    end else if (c == CH_STAR) begin
                        pred_mode = MODE_STMT;
                    end else if (c == CH_SLASH) begin
                        pred_held = HELD_SLASH;
                    end else if (c == CH_PCT) begin
                        pred_held = HELD_PCT;
                    end else begin
                        keep_char(c);
                        pred_mode = MODE_TEXT;
                    end
                end
                MODE_TEXT: begin
                    if (c == CH_SEMI) begin
                        keep_char(c);
                        pred_mode = MODE_START;
                    end else if (c == CH_SLASH) begin
                        pred_held = HELD_SLASH;
                    end else begin
                        keep_char(c);
                    end
                end
                MODE_BLOCK: begin
                    if (c == CH_STAR) pred_held = HELD_STAR;
                end
                default: begin
                    if (c == CH_SEMI) pred_mode = MODE_START;
                end
            endcase
        end
        if (b.stream_last) begin
            if (pred_held == HELD_SLASH) keep_char(CH_SLASH);
            else if (pred_held == HELD_PCT) keep_char(CH_PCT);
            pred_held = HELD_NONE;
            pred_mode = MODE_START;
        end
        if (step_cnt > 0) step_res[step_cnt - 1].run_last = 1'b1;
    endtask

    // Called and returns at a falling edge.
    task automatic send_beat(input in_beat_t b, input logic typed, input logic [1:0] n,
                             input out_beat_t t0, input out_beat_t t1);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        strip_byte(b);
        if (typed) begin
            if (n > 0) kept_q.push_back(t0);
            if (n > 1) kept_q.push_back(t1);
        end else begin
            for (int i = 0; i < step_cnt; i++) kept_q.push_back(step_res[i]);
        end
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (kept_q.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] body_byte();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 8'h61 + 8'($urandom_range(25));
        if (r < 65) begin
            case ($urandom_range(2))
                0: return CH_SP;
                1: return CH_NL;
                default: return CH_TAB;
            endcase
        end
        if (r < 72) return CH_STAR;
        if (r < 78) return CH_SLASH;
        if (r < 82) return CH_PCT;
        if (r < 86) return CH_SEMI;
        return 8'($urandom_range(255));
    endfunction

    task automatic add_segment();
        int kind;
        int len;
        kind = $urandom_range(99);
        len = $urandom_range(1, 8);
        if (kind < 35) begin
            repeat (len) src_q.push_back(body_byte());
            src_q.push_back(CH_SEMI);
            src_q.push_back(CH_NL);
        end else if (kind < 60) begin
            src_q.push_back(CH_SLASH);
            src_q.push_back(CH_STAR);
            repeat (len) src_q.push_back(body_byte());
            src_q.push_back(CH_STAR);
            src_q.push_back(CH_SLASH);
        end else if (kind < 85) begin
            if ($urandom_range(1) == 1) src_q.push_back(CH_PCT);
            src_q.push_back(CH_STAR);
            repeat (len) src_q.push_back(body_byte());
            src_q.push_back(CH_SEMI);
        end else begin
            repeat ($urandom_range(1, 4)) src_q.push_back(8'($urandom_range(255)));
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : check_results
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (kept_q.size() == 0) begin
                $error("unexpected beat: out_byte %h run_last %b",
                       m_data.out_byte, m_data.run_last);
                fail_cnt++;
            end else begin
                want = kept_q.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, m_data.out_byte);
                    fail_cnt++;
                end
                if (m_data.run_last !== want.run_last) begin
                    $error("run_last: expected %b, got %b", want.run_last, m_data.run_last);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == StallLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        in_beat_t beat;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_idle_pct = 7;
        recv_idle_pct = 55;
        foreach (DirTab[i]) begin
            send_beat(DirTab[i].beat, DirTab[i].typed, DirTab[i].n, DirTab[i].r0, DirTab[i].r1);
        end
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 55;
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 7;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // hold the input until the output side has drained
            hold_until_drained();
            repeat (RandPerPhase) begin
                if (src_q.size() == 0) add_segment();
                beat.in_byte = src_q.pop_front();
                beat.stream_last = ($urandom_range(59) == 0);
                send_beat(beat, 1'b0, 2'd0, NoBeat, NoBeat);
            end
        end
        hold_until_drained();
        repeat (8) @(negedge aclk);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
